### rtl/prcl_pkg.sv
// Shared types, constants and codes for the pinned ring change log.
package prcl_pkg;

  localparam int unsigned CAPACITY = 1024;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned FILL_W   = IDX_W + 1;
  localparam int unsigned SEQ_W    = 48;
  localparam int unsigned ENT_W    = 32;
  localparam int unsigned KIND_W   = 8;
  localparam int unsigned EPOCH_W  = 32;
  localparam int unsigned PIN_W    = 16;

  typedef logic [SEQ_W-1:0]   seq_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [FILL_W-1:0]  fill_t;
  typedef logic [ENT_W-1:0]   ent_t;
  typedef logic [KIND_W-1:0]  kind_t;
  typedef logic [EPOCH_W-1:0] epoch_t;
  typedef logic [PIN_W-1:0]   pin_t;

  localparam seq_t  SEQ_MAX   = '1;
  localparam seq_t  SEQ_FIRST = seq_t'(1);
  localparam pin_t  PIN_MAX   = '1;
  localparam fill_t FILL_FULL = fill_t'(CAPACITY);

  typedef enum logic [2:0] {
    OP_APPEND   = 3'd0,
    OP_READ     = 3'd1,
    OP_FETCH    = 3'd2,
    OP_RELEASE  = 3'd3,
    OP_BASELINE = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RESYNC  = 2'd1,
    ST_DROPPED = 2'd2,
    ST_REJECT  = 2'd3
  } status_t;

  typedef struct packed {
    logic  we;
    idx_t  addr;
    ent_t  entity;
    kind_t kind;
  } ring_wr_t;

  typedef struct packed {
    logic re;
    idx_t addr;
  } ring_rd_t;

endpackage

### rtl/prcl_ring_ram.sv
// Ring storage for record entity handles and kind codes, one write and one registered read port.
module prcl_ring_ram (
  input  logic              clk,
  input  prcl_pkg::ring_wr_t wr,
  input  prcl_pkg::ring_rd_t rd,
  output prcl_pkg::ent_t    rd_entity,
  output prcl_pkg::kind_t   rd_kind
);
  import prcl_pkg::*;

  ent_t  mem_entity [CAPACITY];
  kind_t mem_kind   [CAPACITY];
  ent_t  rd_entity_r;
  kind_t rd_kind_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem_entity[wr.addr] <= wr.entity;
      mem_kind[wr.addr]   <= wr.kind;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.re) begin
      rd_entity_r <= mem_entity[rd.addr];
      rd_kind_r   <= mem_kind[rd.addr];
    end
  end

  assign rd_entity = rd_entity_r;
  assign rd_kind   = rd_kind_r;

endmodule

### rtl/pinned_ring_change_log.sv
// Top level of the pinned ring change log: operation decode, log state and result register.
//
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_ready   | opcode, entity, kind, reader_epoch,
//          |           |                       | cursor_seq, record_seq
//  out_    | output    | out_valid / out_ready | status, entity_out, kind_out, range_begin,
//          |           |                       | range_end, new_cursor_epoch, pinned
//
// One operation per cycle while in_ready is high: state updates and the ring access happen
// at the input transfer, and the result is registered in the output register at that edge.
// The ring read data register loads at the same edge, so fetch data comes with the result.
// in_ready is high while the output register is empty or being drained.
// Synchronous active-low reset empties the log; ring contents are not cleared.
module pinned_ring_change_log (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           in_opcode,
  input  prcl_pkg::ent_t       in_entity,
  input  prcl_pkg::kind_t      in_kind,
  input  prcl_pkg::epoch_t     in_reader_epoch,
  input  prcl_pkg::seq_t       in_cursor_seq,
  input  prcl_pkg::seq_t       in_record_seq,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_status,
  output prcl_pkg::ent_t       out_entity_out,
  output prcl_pkg::kind_t      out_kind_out,
  output prcl_pkg::seq_t       out_range_begin,
  output prcl_pkg::seq_t       out_range_end,
  output prcl_pkg::epoch_t     out_new_cursor_epoch,
  output logic                 out_pinned
);
  import prcl_pkg::*;

  // log state
  idx_t   head_r,  head_nxt;
  fill_t  fill_r,  fill_nxt;
  seq_t   oldest_r, oldest_nxt;
  seq_t   next_r,  next_nxt;
  seq_t   minav_r, minav_nxt;
  pin_t   pin_r,   pin_nxt;
  epoch_t epoch_r, epoch_nxt;

  // result register
  logic    out_valid_r;
  status_t status_r,   status_nxt;
  seq_t    rbegin_r,   rbegin_nxt;
  seq_t    rend_r,     rend_nxt;
  epoch_t  cepoch_r,   cepoch_nxt;
  logic    pinned_r,   pinned_nxt;
  logic    fetch_ok_r, fetch_ok_nxt;

  ring_wr_t ring_wr;
  ring_rd_t ring_rd;
  ent_t     rd_entity;
  kind_t    rd_kind;

  logic  xfer_in;
  seq_t  low_seq;
  seq_t  fetch_off;
  seq_t  fill_ext;
  seq_t  seq_p1;
  epoch_t epoch_inc;

  assign in_ready = !out_valid_r || out_ready;
  assign xfer_in  = in_valid && in_ready;

  assign fill_ext  = seq_t'(fill_r);
  assign low_seq   = (oldest_r > minav_r) ? oldest_r : minav_r;
  assign fetch_off = in_record_seq - oldest_r;
  assign seq_p1    = next_r + SEQ_FIRST;
  assign epoch_inc = epoch_r + epoch_t'(1);

  always_comb begin
    head_nxt     = head_r;
    fill_nxt     = fill_r;
    oldest_nxt   = oldest_r;
    next_nxt     = next_r;
    minav_nxt    = minav_r;
    pin_nxt      = pin_r;
    epoch_nxt    = epoch_r;
    status_nxt   = ST_REJECT;
    rbegin_nxt   = '0;
    rend_nxt     = '0;
    cepoch_nxt   = '0;
    pinned_nxt   = 1'b0;
    fetch_ok_nxt = 1'b0;
    ring_wr      = '{we: 1'b0, addr: head_r, entity: in_entity, kind: in_kind};
    ring_rd      = '{re: 1'b0, addr: head_r + fetch_off[IDX_W-1:0]};

    case (opcode_t'(in_opcode))
      OP_APPEND: begin
        if (next_r != SEQ_MAX) begin
          next_nxt = seq_p1;
          if (fill_r == FILL_FULL && pin_r != '0) begin
            minav_nxt  = seq_p1;
            status_nxt = ST_DROPPED;
          end else begin
            status_nxt = ST_OK;
            ring_wr.we = 1'b1;
            if (fill_r == '0 || (oldest_r + fill_ext) != next_r) begin
              // empty ring or a hole after a pinned drop: restart at this record
              oldest_nxt   = next_r;
              fill_nxt     = fill_t'(1);
              ring_wr.addr = head_r;
            end else if (fill_r == FILL_FULL) begin
              // overwrite the oldest slot
              head_nxt     = head_r + idx_t'(1);
              oldest_nxt   = oldest_r + SEQ_FIRST;
              ring_wr.addr = head_r;
            end else begin
              fill_nxt     = fill_r + fill_t'(1);
              ring_wr.addr = head_r + fill_r[IDX_W-1:0];
            end
            if (minav_r < oldest_nxt) begin
              minav_nxt = oldest_nxt;
            end
          end
        end
      end
      OP_READ: begin
        cepoch_nxt = epoch_r;
        if (in_reader_epoch != epoch_r || in_cursor_seq == '0 ||
            in_cursor_seq < low_seq || in_cursor_seq > next_r) begin
          status_nxt = ST_RESYNC;
          rbegin_nxt = next_r;
          rend_nxt   = next_r;
        end else if (in_cursor_seq == next_r) begin
          status_nxt = ST_OK;
          rbegin_nxt = next_r;
          rend_nxt   = next_r;
        end else if (pin_r == PIN_MAX) begin
          status_nxt = ST_REJECT;
          rbegin_nxt = in_cursor_seq;
          rend_nxt   = in_cursor_seq;
        end else begin
          pin_nxt    = pin_r + pin_t'(1);
          status_nxt = ST_OK;
          rbegin_nxt = in_cursor_seq;
          rend_nxt   = next_r;
          pinned_nxt = 1'b1;
        end
      end
      OP_FETCH: begin
        if (fill_r != '0 && in_record_seq >= oldest_r && in_record_seq < next_r &&
            in_record_seq >= minav_r && fetch_off < fill_ext) begin
          status_nxt   = ST_OK;
          fetch_ok_nxt = 1'b1;
          ring_rd.re   = 1'b1;
        end
      end
      OP_RELEASE: begin
        if (pin_r != '0) begin
          pin_nxt    = pin_r - pin_t'(1);
          status_nxt = ST_OK;
        end
      end
      OP_BASELINE: begin
        cepoch_nxt = epoch_r;
        if (pin_r == '0) begin
          // a wrapping baseline skips epoch zero
          epoch_nxt  = (epoch_inc == '0) ? epoch_t'(1) : epoch_inc;
          cepoch_nxt = epoch_nxt;
          head_nxt   = '0;
          fill_nxt   = '0;
          oldest_nxt = SEQ_FIRST;
          next_nxt   = SEQ_FIRST;
          minav_nxt  = SEQ_FIRST;
          status_nxt = ST_OK;
        end
      end
      default: begin
        status_nxt = ST_REJECT;
      end
    endcase

    if (!xfer_in) begin
      ring_wr.we = 1'b0;
      ring_rd.re = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      fill_r      <= '0;
      oldest_r    <= SEQ_FIRST;
      next_r      <= SEQ_FIRST;
      minav_r     <= SEQ_FIRST;
      pin_r       <= '0;
      epoch_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (xfer_in) begin
        head_r      <= head_nxt;
        fill_r      <= fill_nxt;
        oldest_r    <= oldest_nxt;
        next_r      <= next_nxt;
        minav_r     <= minav_nxt;
        pin_r       <= pin_nxt;
        epoch_r     <= epoch_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (xfer_in) begin
      status_r   <= status_nxt;
      rbegin_r   <= rbegin_nxt;
      rend_r     <= rend_nxt;
      cepoch_r   <= cepoch_nxt;
      pinned_r   <= pinned_nxt;
      fetch_ok_r <= fetch_ok_nxt;
    end
  end

  prcl_ring_ram u_ring (
    .clk       (clk),
    .wr        (ring_wr),
    .rd        (ring_rd),
    .rd_entity (rd_entity),
    .rd_kind   (rd_kind)
  );

  assign out_valid            = out_valid_r;
  assign out_status           = status_r;
  assign out_entity_out       = fetch_ok_r ? rd_entity : '0;
  assign out_kind_out         = fetch_ok_r ? rd_kind : '0;
  assign out_range_begin      = rbegin_r;
  assign out_range_end        = rend_r;
  assign out_new_cursor_epoch = cepoch_r;
  assign out_pinned           = pinned_r;

endmodule

### tb/pinned_ring_change_log_tb.sv
// Self-checking testbench for the pinned ring change log: directed and random traffic.
module pinned_ring_change_log_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import prcl_pkg::*;

  localparam logic [2:0] OP_CODE_MAX  = '1;
  localparam int         HOLD_CYCLES  = 400;
  localparam int         STALL_LIMIT  = 4000;
  localparam int         RANDOM_OPS   = 600;
  localparam int         REPORT_LIMIT = 10;
  localparam int         SPAN_CLAMP   = 2000;

  typedef struct packed {
    logic [2:0] opcode;
    ent_t       entity;
    kind_t      kind;
    epoch_t     reader_epoch;
    seq_t       cursor_seq;
    seq_t       record_seq;
  } log_op_t;

  typedef struct packed {
    status_t status;
    ent_t    entity;
    kind_t   kind;
    seq_t    range_begin;
    seq_t    range_end;
    epoch_t  reader_epoch;
    logic    pinned;
  } log_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [2:0] in_opcode = '0;
  ent_t       in_entity = '0;
  kind_t      in_kind = '0;
  epoch_t     in_reader_epoch = '0;
  seq_t       in_cursor_seq = '0;
  seq_t       in_record_seq = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_status;
  ent_t       out_entity_out;
  kind_t      out_kind_out;
  seq_t       out_range_begin;
  seq_t       out_range_end;
  epoch_t     out_new_cursor_epoch;
  logic       out_pinned;

  pinned_ring_change_log dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_opcode            (in_opcode),
    .in_entity            (in_entity),
    .in_kind              (in_kind),
    .in_reader_epoch      (in_reader_epoch),
    .in_cursor_seq        (in_cursor_seq),
    .in_record_seq        (in_record_seq),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_status           (out_status),
    .out_entity_out       (out_entity_out),
    .out_kind_out         (out_kind_out),
    .out_range_begin      (out_range_begin),
    .out_range_end        (out_range_end),
    .out_new_cursor_epoch (out_new_cursor_epoch),
    .out_pinned           (out_pinned)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------- log predictor
  ent_t        log_entity [CAPACITY];
  kind_t       log_kind [CAPACITY];
  int unsigned log_head;
  int unsigned log_fill;
  seq_t        log_oldest;
  seq_t        log_next;
  seq_t        log_min_avail;
  pin_t        log_pins;
  epoch_t      log_epoch;

  log_op_t     op_queue [$];
  log_result_t expected_results [$];

  function automatic void log_clear();
    log_head      = 0;
    log_fill      = 0;
    log_oldest    = SEQ_FIRST;
    log_next      = SEQ_FIRST;
    log_min_avail = SEQ_FIRST;
  endfunction

  function automatic int unsigned log_slot(int unsigned off);
    return (log_head + off) % CAPACITY;
  endfunction

  function automatic status_t log_append(ent_t entity, kind_t kind);
    seq_t        s;
    int unsigned slot;
    if (log_next >= SEQ_MAX) return ST_REJECT;
    s = log_next;
    log_next = s + 1;
    // ring full with a reader pinned: drop the new record, hide everything before it
    if (log_fill >= CAPACITY && log_pins != 0) begin
      log_min_avail = log_next;
      return ST_DROPPED;
    end
    // a hole in the sequence makes older records unreadable: restart the ring here
    if (log_fill == 0 || log_oldest + seq_t'(log_fill) != s) begin
      log_fill   = 0;
      log_oldest = s;
    end else if (log_fill >= CAPACITY) begin
      log_head   = log_slot(1);
      log_oldest = log_oldest + 1;
      log_fill   = log_fill - 1;
    end
    slot = log_slot(log_fill);
    log_entity[slot] = entity;
    log_kind[slot]   = kind;
    log_fill = log_fill + 1;
    if (log_min_avail < log_oldest) log_min_avail = log_oldest;
    return ST_OK;
  endfunction

  function automatic log_result_t log_apply(log_op_t op);
    log_result_t r;
    seq_t        low;
    int unsigned slot;
    r = '0;
    r.status = ST_REJECT;
    case (op.opcode)
      OP_APPEND: r.status = log_append(op.entity, op.kind);
      OP_READ: begin
        low = (log_oldest > log_min_avail) ? log_oldest : log_min_avail;
        r.reader_epoch = log_epoch;
        if (op.reader_epoch != log_epoch || op.cursor_seq == '0 ||
            op.cursor_seq < low || op.cursor_seq > log_next) begin
          r.status      = ST_RESYNC;
          r.range_begin = log_next;
          r.range_end   = log_next;
        end else if (op.cursor_seq == log_next) begin
          r.status      = ST_OK;
          r.range_begin = log_next;
          r.range_end   = log_next;
        end else if (log_pins == PIN_MAX) begin
          r.range_begin = op.cursor_seq;
          r.range_end   = op.cursor_seq;
        end else begin
          log_pins      = log_pins + 1;
          r.status      = ST_OK;
          r.range_begin = op.cursor_seq;
          r.range_end   = log_next;
          r.pinned      = 1'b1;
        end
      end
      OP_FETCH: begin
        if (log_fill != 0 && op.record_seq >= log_oldest && op.record_seq < log_next &&
            op.record_seq >= log_min_avail &&
            op.record_seq - log_oldest < seq_t'(log_fill)) begin
          slot     = log_slot(32'(op.record_seq - log_oldest));
          r.entity = log_entity[slot];
          r.kind   = log_kind[slot];
          r.status = ST_OK;
        end
      end
      OP_RELEASE: begin
        if (log_pins != 0) begin
          log_pins = log_pins - 1;
          r.status = ST_OK;
        end
      end
      OP_BASELINE: begin
        if (log_pins == 0) begin
          log_epoch = log_epoch + 1;
          if (log_epoch == '0) log_epoch = log_epoch + 1;
          log_clear();
          r.status = ST_OK;
        end
        r.reader_epoch = log_epoch;
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers
  function automatic seq_t rand_seq();
    return seq_t'({$urandom(), $urandom()});
  endfunction

  // fields the operation ignores still carry random values
  function automatic log_op_t op_with_noise(logic [2:0] code);
    log_op_t op;
    op.opcode       = code;
    op.entity       = $urandom();
    op.kind         = kind_t'($urandom());
    op.reader_epoch = $urandom();
    op.cursor_seq   = rand_seq();
    op.record_seq   = rand_seq();
    return op;
  endfunction

  function automatic void push_append(ent_t entity, kind_t kind);
    log_op_t op;
    op = op_with_noise(OP_APPEND);
    op.entity = entity;
    op.kind   = kind;
    op_queue.push_back(op);
  endfunction

  function automatic void push_read(epoch_t reader_epoch, seq_t cursor_seq);
    log_op_t op;
    op = op_with_noise(OP_READ);
    op.reader_epoch = reader_epoch;
    op.cursor_seq   = cursor_seq;
    op_queue.push_back(op);
  endfunction

  function automatic void push_fetch(seq_t record_seq);
    log_op_t op;
    op = op_with_noise(OP_FETCH);
    op.record_seq = record_seq;
    op_queue.push_back(op);
  endfunction

  function automatic void push_code(logic [2:0] code);
    op_queue.push_back(op_with_noise(code));
  endfunction

  // mostly well-formed cursors and in-window fetches, built from the predicted state
  function automatic void push_random_op();
    int   pick;
    int   span;
    int   fetch_span;
    seq_t low;
    pick = $urandom_range(99);
    low  = (log_oldest > log_min_avail) ? log_oldest : log_min_avail;
    span = (log_next - low > seq_t'(SPAN_CLAMP)) ? SPAN_CLAMP : int'(log_next - low);
    fetch_span = (log_next - log_oldest > seq_t'(SPAN_CLAMP)) ? SPAN_CLAMP :
                 int'(log_next - log_oldest);
    if (pick < 40) begin
      case ($urandom_range(7))
        0:       push_append('0, '0);
        1:       push_append('1, '1);
        default: push_append($urandom(), kind_t'($urandom()));
      endcase
    end else if (pick < 58) begin
      if ($urandom_range(4) != 0) begin
        push_read(log_epoch, low + seq_t'($urandom_range(span)));
      end else begin
        case ($urandom_range(4))
          0:       push_read(log_epoch, '0);
          1:       push_read(log_epoch, log_next + seq_t'($urandom_range(3, 1)));
          2:       push_read($urandom(), low);
          3:       push_read(log_epoch, low - 1);
          default: push_read(log_epoch, rand_seq());
        endcase
      end
    end else if (pick < 74) begin
      if ($urandom_range(4) != 0)
        push_fetch(log_oldest - 1 + seq_t'($urandom_range(fetch_span + 1)));
      else
        push_fetch(rand_seq());
    end else if (pick < 90) begin
      push_code(OP_RELEASE);
    end else if (pick < 96) begin
      push_code(OP_BASELINE);
    end else begin
      push_code(3'($urandom_range(int'(OP_CODE_MAX), int'(OP_BASELINE) + 1)));
    end
  endfunction

  task automatic wait_log_idle();
    while (op_queue.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  // ---------------------------------------------------------------- driver
  logic    in_taken = 1'b0;
  bit      gaps_on = 1'b1;
  int      burst_left = 0;
  int      gap_left = 0;
  log_op_t drive_op;

  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (gap_left != 0) begin
        gap_left = gap_left - 1;
        in_valid <= 1'b0;
      end else if (op_queue.size() != 0) begin
        drive_op = op_queue.pop_front();
        in_opcode       <= drive_op.opcode;
        in_entity       <= drive_op.entity;
        in_kind         <= drive_op.kind;
        in_reader_epoch <= drive_op.reader_epoch;
        in_cursor_seq   <= drive_op.cursor_seq;
        in_record_seq   <= drive_op.record_seq;
        in_valid        <= 1'b1;
        if (burst_left != 0) begin
          burst_left = burst_left - 1;
        end else if (gaps_on) begin
          burst_left = ($urandom_range(3) == 0) ? $urandom_range(80, 30) : $urandom_range(12);
          gap_left   = $urandom_range(8, 1);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- receiver
  bit hold_req = 1'b0;
  int hold_left = 0;
  int ready_mode = 0;
  int mode_left = 0;
  int rx_tick = 0;

  always @(negedge clk) begin
    rx_tick = rx_tick + 1;
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (mode_left == 0) begin
      ready_mode = $urandom_range(3);
      mode_left  = $urandom_range(256, 32);
    end else begin
      mode_left = mode_left - 1;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      case (ready_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= $urandom_range(1);
        2:       out_ready <= (rx_tick % 4 == 0);
        default: out_ready <= ($urandom_range(7) != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------- monitor
  int fail_count = 0;
  int stall_cycles = 0;

  always @(posedge clk) begin
    log_op_t     taken;
    log_result_t got;
    log_result_t want;
    in_taken <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      taken = {in_opcode, in_entity, in_kind, in_reader_epoch, in_cursor_seq, in_record_seq};
      expected_results.push_back(log_apply(taken));
    end
    if (rst_n && out_valid && out_ready) begin
      got = {status_t'(out_status), out_entity_out, out_kind_out, out_range_begin,
             out_range_end, out_new_cursor_epoch, out_pinned};
      if (expected_results.size() == 0) begin
        fail_count = fail_count + 1;
        if (fail_count <= REPORT_LIMIT)
          $display("ERROR %0t: result transfer with none expected: %p", $realtime, got);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          fail_count = fail_count + 1;
          if (fail_count <= REPORT_LIMIT) begin
            $display("ERROR %0t: result mismatch", $realtime);
            $display("  expected st=%0d ent=%h kind=%h rng=%h..%h ep=%h pin=%b",
                     want.status, want.entity, want.kind, want.range_begin,
                     want.range_end, want.reader_epoch, want.pinned);
            $display("  actual   st=%0d ent=%h kind=%h rng=%h..%h ep=%h pin=%b",
                     got.status, got.entity, got.kind, got.range_begin,
                     got.range_end, got.reader_epoch, got.pinned);
          end
        end
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready))
      stall_cycles = 0;
    else
      stall_cycles = stall_cycles + 1;
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("ERROR: no transfer for %0d cycles", STALL_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- test sequence
  initial begin
    log_clear();
    log_pins  = '0;
    log_epoch = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty log, extremes, pin rules, baseline, unknown codes
    push_read('0, '0);                  // unset cursor
    push_read('0, SEQ_FIRST);           // caught up on an empty log
    push_fetch(SEQ_FIRST);
    push_code(OP_RELEASE);              // nothing pinned
    push_append('1, '1);
    push_append('0, '0);
    push_append($urandom(), kind_t'($urandom()));
    push_fetch(SEQ_FIRST);
    push_fetch(seq_t'(3));
    push_fetch(seq_t'(4));
    push_fetch('0);
    push_fetch(SEQ_MAX);
    push_read('1, SEQ_FIRST);           // stale epoch
    push_read('0, SEQ_MAX);             // cursor ahead of the log
    push_read('0, SEQ_FIRST);           // takes a pin on 1..3
    push_code(OP_BASELINE);             // refused while pinned
    push_code(OP_RELEASE);
    push_code(OP_BASELINE);
    push_read('0, SEQ_FIRST);           // old epoch after baseline
    push_fetch(SEQ_FIRST);              // log was emptied
    for (int c = int'(OP_BASELINE) + 1; c <= int'(OP_CODE_MAX); c++) push_code(3'(c));
    push_append($urandom(), kind_t'($urandom()));
    push_read(epoch_t'(1), SEQ_FIRST);
    push_code(OP_RELEASE);
    wait_log_idle();

    // random traffic; halfway through the receiver holds off to back up the input
    for (int i = 0; i < RANDOM_OPS; i++) begin
      while (op_queue.size() >= 4) @(posedge clk);
      if (i == RANDOM_OPS / 2) hold_req = 1'b1;
      push_random_op();
    end

    wait_log_idle();
    repeat (8) @(posedge clk);
    if (expected_results.size() != 0)
      $display("ERROR: %0d results never arrived", expected_results.size());
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
